### rtl/core/jsu_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

  typedef enum logic [3:0] {
    PH_WAIT   = 4'd0,
    PH_BODY   = 4'd1,
    PH_ESC    = 4'd2,
    PH_HEX1   = 4'd3,
    PH_LOW_BS = 4'd4,
    PH_LOW_U  = 4'd5,
    PH_HEX2   = 4'd6
  } phase_e;

  typedef enum logic [1:0] {
    KIND_BYTE = 2'd0,
    KIND_DONE = 2'd1,
    KIND_ERR  = 2'd2
  } kind_e;

  typedef enum logic [3:0] {
    ERR_NO_OPEN    = 4'd0,
    ERR_CONTROL    = 4'd1,
    ERR_END_ESC    = 4'd2,
    ERR_BAD_ESC    = 4'd3,
    ERR_SHORT_HEX  = 4'd4,
    ERR_BAD_HEX    = 4'd5,
    ERR_NO_LOW     = 4'd6,
    ERR_BAD_LOW    = 4'd7,
    ERR_LONE_LOW   = 4'd8,
    ERR_UNCLOSED   = 4'd9
  } err_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_F      = 8'h66;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_U      = 8'h75;
  localparam logic [7:0] CTRL_LIMIT = 8'h20;

  localparam logic [15:0] HIGH_SURR_MIN = 16'hD800;
  localparam logic [15:0] HIGH_SURR_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_SURR_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_SURR_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE     = 21'h10000;

  // All results caused by one input byte: up to four bytes, or one status.
  typedef struct packed {
    logic [3:0][7:0] data;
    logic [1:0]      last_idx;
    kind_e           kind;
    err_e            code;
  } group_t;

  // Returns {valid, value} for an ASCII hex digit.
  function automatic logic [4:0] hex_digit(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  function automatic group_t status_grp(input kind_e k, input err_e c);
    group_t g;
    g.data     = '0;
    g.last_idx = 2'd0;
    g.kind     = k;
    g.code     = c;
    return g;
  endfunction

  function automatic group_t byte_grp(input logic [7:0] b);
    group_t g;
    g.data     = {24'd0, b};
    g.last_idx = 2'd0;
    g.kind     = KIND_BYTE;
    g.code     = ERR_NO_OPEN;
    return g;
  endfunction

  // UTF-8 encoding of a code point; data[0] is sent first.
  function automatic group_t utf8_grp(input logic [20:0] cp);
    group_t g;
    g.data = '0;
    g.kind = KIND_BYTE;
    g.code = ERR_NO_OPEN;
    if (cp <= 21'h7F) begin
      g.data[0]  = cp[7:0];
      g.last_idx = 2'd0;
    end else if (cp <= 21'h7FF) begin
      g.data[0]  = {3'b110, cp[10:6]};
      g.data[1]  = {2'b10, cp[5:0]};
      g.last_idx = 2'd1;
    end else if (cp <= 21'hFFFF) begin
      g.data[0]  = {4'b1110, cp[15:12]};
      g.data[1]  = {2'b10, cp[11:6]};
      g.data[2]  = {2'b10, cp[5:0]};
      g.last_idx = 2'd2;
    end else begin
      g.data[0]  = {5'b11110, cp[20:18]};
      g.data[1]  = {2'b10, cp[17:12]};
      g.data[2]  = {2'b10, cp[11:6]};
      g.data[3]  = {2'b10, cp[5:0]};
      g.last_idx = 2'd3;
    end
    return g;
  endfunction

endpackage

### rtl/core/jsu_in_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_in_if
// Raw text channel: one byte of the JSON text, or an end marker, per beat.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       text_end;

  modport source (output valid, output in_byte, output text_end, input ready);
  modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

### rtl/core/jsu_out_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_out_if
// Result channel: one decoded byte, completion or error per beat.
// ----------------------------------------------------------------------------
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic [1:0] kind;
  logic [3:0] error_code;
  logic       last_of_run;

  modport source (output valid, output out_byte, output kind, output error_code,
                  output last_of_run, input ready);
  modport sink   (input valid, input out_byte, input kind, input error_code,
                  input last_of_run, output ready);
endinterface

### rtl/core/jsu_decode.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_decode
// Parser state and next-state logic; turns one raw byte into a result group.
// ----------------------------------------------------------------------------
module jsu_decode import jsu_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [7:0] in_byte_i,
  input  logic       text_end_i,
  output group_t     grp_o,
  output logic       grp_valid_o
);

  phase_e      phase_q, phase_d;
  logic [15:0] hex_q, hex_d;
  logic [1:0]  cnt_q, cnt_d;
  logic [9:0]  hs_q, hs_d;

  logic [4:0]  dig;
  logic [15:0] hex_full;
  logic [20:0] cp_pair;

  assign dig      = hex_digit(in_byte_i);
  assign hex_full = {hex_q[11:0], dig[3:0]};
  assign cp_pair  = SUPP_BASE + {1'b0, hs_q, hex_full[9:0]};

  always_comb begin
    phase_d     = phase_q;
    hex_d       = hex_q;
    cnt_d       = cnt_q;
    hs_d        = hs_q;
    grp_o       = status_grp(KIND_BYTE, ERR_NO_OPEN);
    grp_valid_o = 1'b0;
    unique case (phase_q)
      PH_BODY: begin
        grp_valid_o = 1'b1;
        if (text_end_i) begin
          grp_o   = status_grp(KIND_ERR, ERR_UNCLOSED);
          phase_d = PH_WAIT;
        end else if (in_byte_i == CH_QUOTE) begin
          grp_o   = status_grp(KIND_DONE, ERR_NO_OPEN);
          phase_d = PH_WAIT;
        end else if (in_byte_i < CTRL_LIMIT) begin
          grp_o   = status_grp(KIND_ERR, ERR_CONTROL);
          phase_d = PH_WAIT;
        end else if (in_byte_i == CH_BSLASH) begin
          grp_valid_o = 1'b0;
          phase_d     = PH_ESC;
        end else begin
          grp_o = byte_grp(in_byte_i);
        end
      end
      PH_ESC: begin
        grp_valid_o = 1'b1;
        phase_d     = PH_BODY;
        if (text_end_i) begin
          grp_o   = status_grp(KIND_ERR, ERR_END_ESC);
          phase_d = PH_WAIT;
        end else begin
          unique case (in_byte_i)
            CH_QUOTE:  grp_o = byte_grp(CH_QUOTE);
            CH_BSLASH: grp_o = byte_grp(CH_BSLASH);
            CH_SLASH:  grp_o = byte_grp(CH_SLASH);
            CH_B:      grp_o = byte_grp(8'h08);
            CH_F:      grp_o = byte_grp(8'h0C);
            CH_N:      grp_o = byte_grp(8'h0A);
            CH_R:      grp_o = byte_grp(8'h0D);
            CH_T:      grp_o = byte_grp(8'h09);
            CH_U: begin
              grp_valid_o = 1'b0;
              hex_d       = 16'd0;
              cnt_d       = 2'd0;
              phase_d     = PH_HEX1;
            end
            default: begin
              grp_o   = status_grp(KIND_ERR, ERR_BAD_ESC);
              phase_d = PH_WAIT;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        if (text_end_i) begin
          grp_valid_o = 1'b1;
          grp_o       = status_grp(KIND_ERR,
                                   (phase_q == PH_HEX1) ? ERR_SHORT_HEX : ERR_NO_LOW);
          phase_d     = PH_WAIT;
        end else if (!dig[4]) begin
          grp_valid_o = 1'b1;
          grp_o       = status_grp(KIND_ERR, ERR_BAD_HEX);
          phase_d     = PH_WAIT;
        end else begin
          hex_d = hex_full;
          cnt_d = cnt_q + 2'd1;
          if (cnt_q == 2'd3) begin
            if (phase_q == PH_HEX1) begin
              if (hex_full >= HIGH_SURR_MIN && hex_full <= HIGH_SURR_MAX) begin
                hs_d    = hex_full[9:0];
                phase_d = PH_LOW_BS;
              end else if (hex_full >= LOW_SURR_MIN && hex_full <= LOW_SURR_MAX) begin
                grp_valid_o = 1'b1;
                grp_o       = status_grp(KIND_ERR, ERR_LONE_LOW);
                phase_d     = PH_WAIT;
              end else begin
                grp_valid_o = 1'b1;
                grp_o       = utf8_grp({5'd0, hex_full});
                phase_d     = PH_BODY;
              end
            end else begin
              grp_valid_o = 1'b1;
              if (hex_full < LOW_SURR_MIN || hex_full > LOW_SURR_MAX) begin
                grp_o   = status_grp(KIND_ERR, ERR_BAD_LOW);
                phase_d = PH_WAIT;
              end else begin
                grp_o   = utf8_grp(cp_pair);
                phase_d = PH_BODY;
              end
            end
          end
        end
      end
      PH_LOW_BS: begin
        if (text_end_i || in_byte_i != CH_BSLASH) begin
          grp_valid_o = 1'b1;
          grp_o       = status_grp(KIND_ERR, ERR_NO_LOW);
          phase_d     = PH_WAIT;
        end else begin
          phase_d = PH_LOW_U;
        end
      end
      PH_LOW_U: begin
        if (text_end_i || in_byte_i != CH_U) begin
          grp_valid_o = 1'b1;
          grp_o       = status_grp(KIND_ERR, ERR_NO_LOW);
          phase_d     = PH_WAIT;
        end else begin
          hex_d   = 16'd0;
          cnt_d   = 2'd0;
          phase_d = PH_HEX2;
        end
      end
      default: begin
        // Waiting for an opening quote; unused codes behave the same.
        if (text_end_i || in_byte_i != CH_QUOTE) begin
          grp_valid_o = 1'b1;
          grp_o       = status_grp(KIND_ERR, ERR_NO_OPEN);
          phase_d     = PH_WAIT;
        end else begin
          phase_d = PH_BODY;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_WAIT;
      hex_q   <= 16'd0;
      cnt_q   <= 2'd0;
      hs_q    <= 10'd0;
    end else if (step_i) begin
      phase_q <= phase_d;
      hex_q   <= hex_d;
      cnt_q   <= cnt_d;
      hs_q    <= hs_d;
    end
  end

endmodule

### rtl/core/json_string_unescape_utf8.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a JSON string token byte by byte into UTF-8 bytes and status beats.
// ----------------------------------------------------------------------------
// Each input byte's result group is queued on acceptance and offered from the queue head.
// Throughput: one input byte per cycle while the result queue (two groups) has room; it
//   drains one beat per cycle while the output is ready; n results take n output beats.
// Reset: parser waits for an opening quote, hex state cleared, result queue empty.
module json_string_unescape_utf8 import jsu_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);

  group_t     mem_q [2];
  logic       wr_ptr_q, rd_ptr_q;
  logic [1:0] count_q, count_d;
  logic [1:0] idx_q;

  group_t     grp;
  logic       grp_valid;
  logic       in_fire, push, pop, out_fire, at_last;
  group_t     head;

  assign in_i.ready = (count_q != 2'd2);
  assign in_fire    = in_i.valid && in_i.ready;

  jsu_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .step_i      (in_fire),
    .in_byte_i   (in_i.in_byte),
    .text_end_i  (in_i.text_end),
    .grp_o       (grp),
    .grp_valid_o (grp_valid)
  );

  assign push     = in_fire && grp_valid;
  assign head     = mem_q[rd_ptr_q];
  assign at_last  = (idx_q == head.last_idx);
  assign out_fire = out_o.valid && out_o.ready;
  assign pop      = out_fire && at_last;

  assign out_o.valid       = (count_q != 2'd0);
  assign out_o.out_byte    = head.data[idx_q];
  assign out_o.kind        = head.kind;
  assign out_o.error_code  = head.code;
  assign out_o.last_of_run = at_last;

  always_comb begin
    count_d = count_q;
    if (push && !pop) begin
      count_d = count_q + 2'd1;
    end else if (pop && !push) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= grp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
      idx_q    <= 2'd0;
    end else begin
      count_q <= count_d;
      if (push) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
        idx_q    <= 2'd0;
      end else if (out_fire) begin
        idx_q <= idx_q + 2'd1;
      end
    end
  end

  // The queue holds at most two groups.
  assert property (@(posedge clk_i) disable iff (!rst_ni) count_q <= 2'd2)
    else $error("result queue overflow");

  // The beat index never runs past the last byte of the group at the head.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> idx_q <= head.last_idx)
    else $error("beat index beyond group end");

  // Completion and error beats are always the only beat of their group.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kind != KIND_BYTE) |-> (out_o.last_of_run && idx_q == 2'd0))
    else $error("status beat not alone in its group");

  // A pop with no push frees a slot, so the input side is ready next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop && !push) |=> in_i.ready)
    else $error("input not ready after queue pop");

endmodule

### test/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives JSON string tokens into the unescaper one byte per beat: directed
// strings for every escape form and every error, then random well-formed and
// broken strings with noise between them. Each result beat is checked against
// a cycle-free model of the parser kept in this file.
// ----------------------------------------------------------------------------
module tb_top;
  import jsu_pkg::*;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    err_e       code;
    logic       last;
  } beat_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  jsu_in_if  in_if ();
  jsu_out_if out_if ();

  json_string_unescape_utf8 dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_if),
    .out_o (out_if)
  );

  always #5 clk_i = ~clk_i;

  // Parser state as the model sees it.
  phase_e      parse_phase;
  logic [15:0] hex_acc;
  logic [1:0]  hex_count;
  logic [9:0]  high_bits;

  beat_t pending_beats[$];
  beat_t want_beat;
  int    fail_count = 0;
  int    items_sent = 0;
  int    gap_pct = 6;
  int    stall_pct = 6;

  logic [7:0] short_escapes [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R,
                                    CH_T};

  function automatic beat_t mk_beat(input logic [7:0] data, input kind_e kind,
                                    input err_e code);
    beat_t b;
    b.data = data;
    b.kind = kind;
    b.code = code;
    b.last = 1'b0;
    return b;
  endfunction

  // Appends one expected beat to the tail of the pending list.
  function automatic void queue_beat(input logic [7:0] data, input kind_e kind,
                                     input err_e code);
    pending_beats.insert(pending_beats.size(), mk_beat(data, kind, code));
  endfunction

  function automatic int hex_val(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h37;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h57;
    return -1;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'h30 + {4'd0, n};
    return ($urandom_range(1) ? 8'h41 : 8'h61) + {4'd0, n} - 8'd10;
  endfunction

  // Advances the model by one input beat and queues the results it causes.
  task automatic decode_expected(input logic [7:0] c, input bit is_end);
    int          first_new;
    logic [20:0] cp;
    bit          emit_cp;
    bit          failed;
    err_e        err;
    int          nib;
    first_new = pending_beats.size();
    emit_cp   = 1'b0;
    failed    = 1'b0;
    err       = ERR_NO_OPEN;
    cp        = '0;
    case (parse_phase)
      PH_BODY: begin
        if (is_end) begin
          failed = 1'b1;
          err    = ERR_UNCLOSED;
        end else if (c == CH_QUOTE) begin
          queue_beat(8'h00, KIND_DONE, ERR_NO_OPEN);
          parse_phase = PH_WAIT;
        end else if (c < CTRL_LIMIT) begin
          failed = 1'b1;
          err    = ERR_CONTROL;
        end else if (c == CH_BSLASH) begin
          parse_phase = PH_ESC;
        end else begin
          queue_beat(c, KIND_BYTE, ERR_NO_OPEN);
        end
      end
      PH_ESC: begin
        if (is_end) begin
          failed = 1'b1;
          err    = ERR_END_ESC;
        end else begin
          parse_phase = PH_BODY;
          case (c)
            CH_QUOTE, CH_BSLASH, CH_SLASH: queue_beat(c, KIND_BYTE, ERR_NO_OPEN);
            CH_B: queue_beat(8'h08, KIND_BYTE, ERR_NO_OPEN);
            CH_F: queue_beat(8'h0C, KIND_BYTE, ERR_NO_OPEN);
            CH_N: queue_beat(8'h0A, KIND_BYTE, ERR_NO_OPEN);
            CH_R: queue_beat(8'h0D, KIND_BYTE, ERR_NO_OPEN);
            CH_T: queue_beat(8'h09, KIND_BYTE, ERR_NO_OPEN);
            CH_U: begin
              hex_acc     = '0;
              hex_count   = '0;
              parse_phase = PH_HEX1;
            end
            default: begin
              failed = 1'b1;
              err    = ERR_BAD_ESC;
            end
          endcase
        end
      end
      PH_HEX1, PH_HEX2: begin
        nib = hex_val(c);
        if (is_end) begin
          failed = 1'b1;
          err    = (parse_phase == PH_HEX1) ? ERR_SHORT_HEX : ERR_NO_LOW;
        end else if (nib < 0) begin
          failed = 1'b1;
          err    = ERR_BAD_HEX;
        end else begin
          hex_acc = {hex_acc[11:0], nib[3:0]};
          if (hex_count != 2'd3) begin
            hex_count++;
          end else begin
            hex_count = '0;
            if (parse_phase == PH_HEX2) begin
              if (hex_acc < LOW_SURR_MIN || hex_acc > LOW_SURR_MAX) begin
                failed = 1'b1;
                err    = ERR_BAD_LOW;
              end else begin
                cp      = SUPP_BASE + {1'b0, high_bits, 10'(hex_acc - LOW_SURR_MIN)};
                emit_cp = 1'b1;
              end
            end else if (hex_acc >= HIGH_SURR_MIN && hex_acc <= HIGH_SURR_MAX) begin
              // The high surrogate base has its low ten bits clear.
              high_bits   = hex_acc[9:0];
              parse_phase = PH_LOW_BS;
            end else if (hex_acc >= LOW_SURR_MIN && hex_acc <= LOW_SURR_MAX) begin
              failed = 1'b1;
              err    = ERR_LONE_LOW;
            end else begin
              cp      = {5'd0, hex_acc};
              emit_cp = 1'b1;
            end
          end
        end
      end
      PH_LOW_BS: begin
        if (is_end || c != CH_BSLASH) begin
          failed = 1'b1;
          err    = ERR_NO_LOW;
        end else begin
          parse_phase = PH_LOW_U;
        end
      end
      PH_LOW_U: begin
        if (is_end || c != CH_U) begin
          failed = 1'b1;
          err    = ERR_NO_LOW;
        end else begin
          hex_acc     = '0;
          hex_count   = '0;
          parse_phase = PH_HEX2;
        end
      end
      default: begin
        if (is_end || c != CH_QUOTE) begin
          failed = 1'b1;
          err    = ERR_NO_OPEN;
        end else begin
          parse_phase = PH_BODY;
        end
      end
    endcase

    if (failed) begin
      queue_beat(8'h00, KIND_ERR, err);
      parse_phase = PH_WAIT;
    end
    if (emit_cp) begin
      parse_phase = PH_BODY;
      if (cp < 21'h80) begin
        queue_beat(cp[7:0], KIND_BYTE, ERR_NO_OPEN);
      end else if (cp <= 21'h7FF) begin
        queue_beat({3'b110, cp[10:6]}, KIND_BYTE, ERR_NO_OPEN);
        queue_beat({2'b10, cp[5:0]}, KIND_BYTE, ERR_NO_OPEN);
      end else if (cp <= 21'hFFFF) begin
        queue_beat({4'b1110, cp[15:12]}, KIND_BYTE, ERR_NO_OPEN);
        queue_beat({2'b10, cp[11:6]}, KIND_BYTE, ERR_NO_OPEN);
        queue_beat({2'b10, cp[5:0]}, KIND_BYTE, ERR_NO_OPEN);
      end else begin
        queue_beat({5'b11110, cp[20:18]}, KIND_BYTE, ERR_NO_OPEN);
        queue_beat({2'b10, cp[17:12]}, KIND_BYTE, ERR_NO_OPEN);
        queue_beat({2'b10, cp[11:6]}, KIND_BYTE, ERR_NO_OPEN);
        queue_beat({2'b10, cp[5:0]}, KIND_BYTE, ERR_NO_OPEN);
      end
    end
    if (pending_beats.size() > first_new) begin
      pending_beats[pending_beats.size() - 1].last = 1'b1;
    end
  endtask

  // Valid stays high after a beat is taken, so back-to-back beats need no
  // second assignment in the same step.
  task automatic send_item(input logic [7:0] b, input bit is_end);
    while ($urandom_range(99) < gap_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid    <= 1'b1;
    in_if.in_byte  <= is_end ? 8'($urandom_range(255)) : b;
    in_if.text_end <= is_end;
    do @(posedge clk_i); while (!in_if.ready);
    decode_expected(b, is_end);
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
  endtask

  task automatic send_u_escape(input logic [15:0] v);
    send_item(CH_BSLASH, 1'b0);
    send_item(CH_U, 1'b0);
    for (int i = 3; i >= 0; i--) send_item(hex_char(v[4*i +: 4]), 1'b0);
  endtask

  task automatic wait_all_results();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_beats.size() != 0) @(posedge clk_i);
    // Keep sampling afterwards so that a stray beat would still be seen.
    repeat (6) @(posedge clk_i);
  endtask

  task automatic note_failure(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endtask

  // Result sink: random stalls and the check of every accepted beat.
  initial begin
    out_if.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_if.valid && out_if.ready) begin
        if (pending_beats.size() == 0) begin
          note_failure($sformatf("unexpected beat: byte %02h kind %0d code %0d last %0b",
                                 out_if.out_byte, out_if.kind, out_if.error_code,
                                 out_if.last_of_run));
        end else begin
          want_beat = pending_beats.pop_front();
          if (out_if.out_byte !== want_beat.data || out_if.kind !== want_beat.kind ||
              out_if.error_code !== want_beat.code ||
              out_if.last_of_run !== want_beat.last) begin
            note_failure($sformatf({"mismatch: expected byte %02h kind %0d code %0d last %0b,",
                                    " got byte %02h kind %0d code %0d last %0b"},
                                   want_beat.data, want_beat.kind, want_beat.code,
                                   want_beat.last, out_if.out_byte, out_if.kind,
                                   out_if.error_code, out_if.last_of_run));
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic test_outside_string();
    send_item(8'h41, 1'b0);
    send_item(8'h00, 1'b0);
    send_item(8'hFF, 1'b0);
    send_item(8'h5A, 1'b1);
    wait_all_results();
  endtask

  task automatic test_plain_and_short_escapes();
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h20, 1'b0);
    send_item(8'h7F, 1'b0);
    send_item(8'h80, 1'b0);
    send_item(8'hFF, 1'b0);
    foreach (short_escapes[i]) begin
      send_item(CH_BSLASH, 1'b0);
      send_item(short_escapes[i], 1'b0);
    end
    send_item(CH_QUOTE, 1'b0);
    send_text("\"\"");
    wait_all_results();
  endtask

  task automatic test_unicode_escapes();
    logic [15:0] bmp_points [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800,
                                    16'hD7FF, 16'hE000, 16'hFFFF};
    send_item(CH_QUOTE, 1'b0);
    foreach (bmp_points[i]) send_u_escape(bmp_points[i]);
    send_u_escape(HIGH_SURR_MIN);
    send_u_escape(LOW_SURR_MIN);
    send_u_escape(HIGH_SURR_MAX);
    send_u_escape(LOW_SURR_MAX);
    send_u_escape(16'hD834);
    send_u_escape(16'hDD1E);
    send_item(CH_QUOTE, 1'b0);
    wait_all_results();
  endtask

  task automatic test_error_paths();
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h1F, 1'b0);
    send_item(CH_QUOTE, 1'b0);
    send_item(8'h00, 1'b0);
    send_text("\"\\");
    send_item(8'h00, 1'b1);
    send_text("\"\\x");
    send_text("\"\\u12");
    send_item(8'h00, 1'b1);
    send_text("\"\\u1G");
    send_text("\"\\uD800");
    send_item(8'h00, 1'b1);
    send_text("\"\\uD800A");
    send_text("\"\\uD800\\x");
    send_text("\"\\uD800\\u");
    send_item(8'h00, 1'b1);
    send_text("\"\\uD800\\uDC");
    send_item(8'h00, 1'b1);
    send_text("\"\\uD800\\uDCZ");
    send_text("\"\\uD800\\u0041");
    send_text("\"\\udbff\\ue000");
    send_text("\"\\uDC00");
    send_text("\"\\udfff");
    send_text("\"ab");
    send_item(8'h00, 1'b1);
    wait_all_results();
  endtask

  // One random string token, mostly well formed, sometimes cut short or
  // broken, sometimes preceded by stray bytes outside any string.
  task automatic send_random_string();
    int          pick;
    logic [15:0] v;
    logic [7:0]  b;
    if ($urandom_range(99) < 15) begin
      repeat ($urandom_range(1, 2)) begin
        b = 8'($urandom_range(255));
        if (b == CH_QUOTE) b = 8'h21;
        send_item(b, $urandom_range(99) < 20);
      end
    end
    send_item(CH_QUOTE, 1'b0);
    repeat ($urandom_range(0, 5)) begin
      pick = $urandom_range(99);
      if (pick < 45) begin
        b = 8'($urandom_range(8'h20, 8'hFF));
        if (b == CH_QUOTE || b == CH_BSLASH) b = b + 8'h01;
        send_item(b, 1'b0);
      end else if (pick < 60) begin
        send_item(CH_BSLASH, 1'b0);
        send_item(short_escapes[3'($urandom_range(7))], 1'b0);
      end else if (pick < 85) begin
        case ($urandom_range(3))
          0: v = 16'($urandom_range(16'h007F));
          1: v = 16'($urandom_range(16'h0080, 16'h07FF));
          2: v = 16'($urandom_range(16'h0800, 16'hD7FF));
          default: v = 16'($urandom_range(16'hE000, 16'hFFFF));
        endcase
        send_u_escape(v);
      end else begin
        send_u_escape(16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX)));
        send_u_escape(16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX)));
      end
    end
    if ($urandom_range(99) < 75) begin
      send_item(CH_QUOTE, 1'b0);
    end else begin
      case ($urandom_range(8))
        0: send_item(8'($urandom_range(8'h1F)), 1'b0);
        1: send_item(8'h00, 1'b1);
        2: begin
          send_item(CH_BSLASH, 1'b0);
          send_item(8'h00, 1'b1);
        end
        3: begin
          do b = 8'($urandom_range(255));
          while (b inside {CH_QUOTE, CH_BSLASH, CH_SLASH, CH_B, CH_F, CH_N, CH_R, CH_T, CH_U});
          send_item(CH_BSLASH, 1'b0);
          send_item(b, 1'b0);
        end
        4, 5: begin
          pick = $urandom_range(1);
          send_item(CH_BSLASH, 1'b0);
          send_item(CH_U, 1'b0);
          repeat ($urandom_range(3)) send_item(hex_char(4'($urandom_range(15))), 1'b0);
          do b = 8'($urandom_range(255)); while (hex_val(b) >= 0);
          send_item(b, pick == 0);
        end
        6: begin
          send_u_escape(16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX)));
          case ($urandom_range(4))
            0: send_item(8'h00, 1'b1);
            1: begin
              b = 8'($urandom_range(255));
              if (b == CH_BSLASH) b = 8'h41;
              send_item(b, 1'b0);
            end
            2: begin
              b = 8'($urandom_range(255));
              if (b == CH_U) b = 8'h76;
              send_item(CH_BSLASH, 1'b0);
              send_item(b, $urandom_range(3) == 0);
            end
            default: begin
              send_item(CH_BSLASH, 1'b0);
              send_item(CH_U, 1'b0);
              repeat ($urandom_range(3)) send_item(hex_char(4'($urandom_range(15))), 1'b0);
              do b = 8'($urandom_range(255)); while (hex_val(b) >= 0);
              send_item(b, $urandom_range(1) == 0);
            end
          endcase
        end
        7: begin
          v = 16'($urandom);
          if (v >= LOW_SURR_MIN && v <= LOW_SURR_MAX) v = v ^ 16'h2000;
          send_u_escape(16'($urandom_range(HIGH_SURR_MIN, HIGH_SURR_MAX)));
          send_u_escape(v);
        end
        default: send_u_escape(16'($urandom_range(LOW_SURR_MIN, LOW_SURR_MAX)));
      endcase
    end
  endtask

  task automatic test_random_strings();
    int first;
    first = items_sent;
    // First half at full rate on both sides, second half with random gaps.
    gap_pct   = 0;
    stall_pct = 0;
    while (items_sent - first < 50) send_random_string();
    gap_pct   = 6;
    stall_pct = 6;
    while (items_sent - first < 100) send_random_string();
    wait_all_results();
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.in_byte  = 8'h00;
    in_if.text_end = 1'b0;
    parse_phase    = PH_WAIT;
    hex_acc        = '0;
    hex_count      = '0;
    high_bits      = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_outside_string();
    test_plain_and_short_escapes();
    test_unicode_escapes();
    test_error_paths();
    test_random_strings();

    if (fail_count == 0 && pending_beats.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  initial begin
    #1ms;
    $display("Some tests failed");
    $finish;
  end

endmodule
